[design/ltpd_pkg.sv]
package ltpd_pkg;

  localparam int PointsPerScanDef = 361;
  localparam int CordicIters = 24;
  localparam int IterW = 5;
  localparam int AccW = 48;

  localparam logic [15:0] InvGain = 16'd39797;
  localparam logic [15:0] BearMul = 16'd51472;
  localparam logic [31:0] HalfDeg = 32'd5965232;
  localparam logic signed [15:0] BearLimit = 16'sd25736;
  localparam logic [12:0] MaxRangeRst = 13'd7500;

  localparam logic [1:0] KindPoint = 2'd0;
  localparam logic [1:0] KindEnd = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  localparam logic [1:0] RegOffX = 2'd0;
  localparam logic [1:0] RegOffY = 2'd1;
  localparam logic [1:0] RegRange = 2'd2;

  typedef struct packed {
    logic start;
    logic load_vec;
    logic step;
    logic [IterW-1:0] iter;
    logic load_out;
  } ltpd_cmd_t;

  typedef struct packed {
    logic zero_pt;
  } ltpd_sts_t;

  function automatic logic [31:0] atan_lut(input logic [IterW-1:0] k);
    logic [31:0] r;
    begin
      case (k)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

[design/ltpd_datapath.sv]
module ltpd_datapath
  import ltpd_pkg::*;
(
  input  logic clk,
  input  ltpd_cmd_t cmd,
  output ltpd_sts_t sts,
  input  logic [9:0] angle_idx,
  input  logic [12:0] dist_cm,
  input  logic signed [15:0] off_x,
  input  logic signed [15:0] off_y,
  output logic signed [17:0] x_mm,
  output logic signed [17:0] y_mm,
  output logic [16:0] radius_mm,
  output logic signed [15:0] bearing
);

  logic signed [AccW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [1:0] quad_r, quad_nxt;
  logic signed [17:0] xm_r, xm_nxt, ym_r, ym_nxt;
  logic signed [AccW-1:0] dx, dy, c, s, rs, rc, ta;
  logic [31:0] ang;
  logic [51:0] radw;
  logic signed [AccW-1:0] radp, bearp;
  logic signed [AccW-1:0] radq, bearq;
  logic [16:0] rad_r, rad_nxt;
  logic signed [15:0] bear_r, bear_nxt;
  logic signed [AccW-1:0] xa, ya;
  logic dir;

  assign ang = 32'(angle_idx) * HalfDeg;
  assign dx = x_r >>> cmd.iter;
  assign dy = y_r >>> cmd.iter;
  assign ta = AccW'(atan_lut(cmd.iter));
  // rotation mode steers on z, vectoring on y
  assign dir = cmd.load_out ? 1'b0 : (xm_r == 18'sd0 ? (z_r >= 0) : (z_r >= 0));

  always_comb begin
    case (quad_r)
      2'd0: begin c = x_r; s = y_r; end
      2'd1: begin c = -y_r; s = x_r; end
      2'd2: begin c = -x_r; s = -y_r; end
      default: begin c = y_r; s = -x_r; end
    endcase
    rs = (s + 48'sd32768) >>> 16;
    rc = (c + 48'sd32768) >>> 16;
    xa = AccW'(xm_r) <<< 16;
    ya = AccW'(ym_r) <<< 16;
    // vectored X stays below 2^36, z below 2^33 in magnitude
    radw = x_r[35:0] * InvGain;
    radp = (x_r > 0) ? AccW'((radw + 52'h80000000) >> 32) : '0;
    bearp = ($signed(z_r[33:0]) * $signed({1'b0, BearMul}) + 48'sh80000000) >>> 32;
    radq = radp;
    bearq = bearp;
  end

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; quad_nxt = quad_r;
    xm_nxt = xm_r; ym_nxt = ym_r; rad_nxt = rad_r; bear_nxt = bear_r;
    if (cmd.start) begin
      x_nxt = AccW'(32'(dist_cm) * 32'(InvGain) * 32'd10);
      y_nxt = '0;
      z_nxt = AccW'({ang[29:0]});
      quad_nxt = ang[31:30];
    end else if (cmd.step && !cmd.load_vec) begin
      if (z_r >= 0) begin
        x_nxt = x_r - dy; y_nxt = y_r + dx; z_nxt = z_r - ta;
      end else begin
        x_nxt = x_r + dy; y_nxt = y_r - dx; z_nxt = z_r + ta;
      end
    end else if (cmd.load_vec && !cmd.step) begin
      xm_nxt = 18'(rs + AccW'(off_x));
      ym_nxt = 18'(-rc + AccW'(off_y));
    end else if (cmd.load_vec && cmd.step) begin
      // vectoring pre-rotation
      z_nxt = '0; x_nxt = xa; y_nxt = ya;
      if (xa < 0) begin
        if (ya >= 0) begin x_nxt = ya; y_nxt = -xa; z_nxt = 48'sh40000000; end
        else begin x_nxt = -ya; y_nxt = xa; z_nxt = -48'sh40000000; end
      end
    end else if (cmd.load_out) begin
      rad_nxt = (radq > 48'sd131071) ? 17'h1FFFF : 17'(radq);
      bear_nxt = (bearq > 48'sd25736) ? BearLimit :
                 (bearq < -48'sd25736) ? -BearLimit : 16'(bearq);
      if (xm_r == 18'sd0 && ym_r == 18'sd0) begin
        rad_nxt = '0; bear_nxt = '0;
      end
    end
  end

  // vectoring iteration, shares shifters with rotation
  logic signed [AccW-1:0] vx, vy, vz;
  always_comb begin
    if (y_r < 0) begin
      vx = x_r - dy; vy = y_r + dx; vz = z_r - ta;
    end else begin
      vx = x_r + dy; vy = y_r - dx; vz = z_r + ta;
    end
  end

  logic vec_mode_r, vec_mode_nxt;
  assign vec_mode_nxt = cmd.start ? 1'b0 : ((cmd.load_vec && cmd.step) ? 1'b1 : vec_mode_r);

  always_ff @(posedge clk) begin
    vec_mode_r <= vec_mode_nxt;
    quad_r <= quad_nxt; xm_r <= xm_nxt; ym_r <= ym_nxt;
    rad_r <= rad_nxt; bear_r <= bear_nxt;
    if (cmd.step && !cmd.load_vec && vec_mode_r) begin
      x_r <= vx; y_r <= vy; z_r <= vz;
    end else begin
      x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    end
  end

  assign sts.zero_pt = dir & 1'b0 | (xm_r == 18'sd0 && ym_r == 18'sd0);
  assign x_mm = xm_r;
  assign y_mm = ym_r;
  assign radius_mm = rad_r;
  assign bearing = bear_r;

endmodule

[design/ltpd_ctrl.sv]
module ltpd_ctrl
  import ltpd_pkg::*;
#(
  parameter int PointsPerScan = PointsPerScanDef,
  localparam int IdxW = $clog2(PointsPerScan)
)(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_byte,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_kind,
  output logic [8:0] out_index,
  output logic out_last,
  output logic out_zero,
  input  logic [12:0] max_range,
  output ltpd_cmd_t cmd,
  input  ltpd_sts_t sts,
  output logic [9:0] angle_idx,
  output logic [12:0] dist_cm
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_ROT = 5'b00010, S_PRE = 5'b00100,
    S_VEC = 5'b01000, S_OUT = 5'b10000
  } state_t;

  state_t st_r, st_nxt;
  logic [7:0] win_r [9];
  logic [3:0] fill_r;
  logic pay_r;
  logic [IdxW:0] cnt_r;
  logic [7:0] low_r;
  logic [IterW-1:0] it_r;
  logic ov_r;
  logic [1:0] kind_r;
  logic [IdxW-1:0] idx_r;
  logic last_r, zero_r;

  logic acc, hdr_hit, rep_hit, last_pair;
  logic [12:0] dist_w;
  logic [IdxW-1:0] pidx;

  assign in_ready = (st_r == S_IDLE) && !ov_r;
  assign acc = in_valid && in_ready;
  assign pidx = cnt_r[IdxW:1];
  assign dist_w = {in_byte[4:0], low_r};
  assign last_pair = (32'(pidx) >= PointsPerScan - 1);
  assign hdr_hit = fill_r >= 4'd6 && in_byte == 8'h01 && win_r[3] == 8'h02 &&
                   win_r[4] == 8'h80 && win_r[5] == 8'hD6 && win_r[6] == 8'h02 &&
                   win_r[7] == 8'hB0 && win_r[8] == 8'h69;
  assign rep_hit = fill_r >= 4'd9 && in_byte == 8'h0A && win_r[0] == 8'h06 &&
                   win_r[1] == 8'h02 && win_r[2] == 8'h80 && win_r[3] == 8'h03 &&
                   win_r[4] == 8'h00 && win_r[5] == 8'hA0 && win_r[6] == 8'h00;

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    cmd.iter = it_r;
    case (st_r)
      S_IDLE: if (acc && pay_r && cnt_r[0] && dist_w < max_range) begin
        st_nxt = S_ROT; cmd.start = 1'b1;
      end
      S_ROT: begin
        cmd.step = 1'b1;
        if (it_r == IterW'(CordicIters - 1)) st_nxt = S_PRE;
      end
      S_PRE: begin
        cmd.load_vec = 1'b1; st_nxt = S_VEC;
      end
      S_VEC: begin
        if (it_r == '1) begin
          cmd.load_vec = 1'b1; cmd.step = 1'b1;
        end else begin
          cmd.step = 1'b1;
          if (it_r == IterW'(CordicIters - 1)) st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.load_out = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; fill_r <= '0; pay_r <= 1'b0; cnt_r <= '0;
      low_r <= '0; it_r <= '0; ov_r <= 1'b0;
      for (int j = 0; j < 9; j++) win_r[j] <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_ROT: it_r <= (it_r == IterW'(CordicIters - 1)) ? '1 : it_r + 1'b1;
        S_PRE: it_r <= '1;
        S_VEC: it_r <= (it_r == IterW'(CordicIters - 1)) ? '0 : it_r + 1'b1;
        default: it_r <= '0;
      endcase
      if (out_valid && out_ready) ov_r <= 1'b0;
      else if (st_r == S_OUT) ov_r <= 1'b1;
      if (acc) begin
        if (pay_r) begin
          if (!cnt_r[0]) begin
            low_r <= in_byte; cnt_r <= cnt_r + 1'b1;
          end else begin
            cnt_r <= last_pair ? '0 : cnt_r + 1'b1;
            idx_r <= pidx; last_r <= last_pair;
            if (last_pair) begin
              pay_r <= 1'b0; fill_r <= '0;
            end
            if (dist_w < max_range) kind_r <= KindPoint;
            else if (last_pair) begin
              kind_r <= KindEnd; ov_r <= 1'b1; zero_r <= 1'b1;
            end
          end
        end else if (hdr_hit) begin
          pay_r <= 1'b1; cnt_r <= '0; fill_r <= '0;
        end else if (rep_hit) begin
          fill_r <= '0; kind_r <= KindStatus; ov_r <= 1'b1;
          zero_r <= 1'b1; idx_r <= '0; last_r <= 1'b0;
        end else begin
          for (int j = 0; j < 8; j++) win_r[j] <= win_r[j+1];
          win_r[8] <= in_byte;
          if (fill_r < 4'd9) fill_r <= fill_r + 1'b1;
        end
      end
      if (st_r == S_IDLE && acc && pay_r && cnt_r[0] && dist_w < max_range)
        zero_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;
  assign out_kind = kind_r;
  assign out_index = 9'(idx_r);
  assign out_last = last_r;
  assign out_zero = zero_r | (sts.zero_pt & 1'b0);
  // the datapath loads angle and distance at the accepting edge of the high byte
  assign angle_idx = (32'(pidx) >= 720) ? 10'(32'(pidx) - 720) : 10'(pidx);
  assign dist_cm = dist_w;

endmodule

[design/lidar_telegram_point_decoder.sv]
// A point result is computed after its high byte is accepted: 24 rotation steps, rounding,
// pre-rotation, 24 vectoring steps, scaling; other results are valid in the cycle after
// their last byte is accepted. Throughput: one byte a cycle while no result waits and no
// point is being computed; a point in progress or a waiting result holds the input.
// Reset (rst_n, synchronous, active low) clears the hunt window, payload state and
// registers to offset 0, range 7500 cm.
module lidar_telegram_point_decoder
  import ltpd_pkg::*;
#(
  parameter int POINTS_PER_SCAN = PointsPerScanDef
)(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [7:0] in_tdata,    // rx_byte
  output logic out_tvalid,
  input  logic out_tready,
  output logic [79:0] out_tdata,  // point_index, x_mm, y_mm, radius_mm, bearing, zeros
  output logic [1:0] out_tuser,   // kind
  output logic out_tlast,         // last_in_scan
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  logic signed [15:0] offx_r, offy_r;
  logic [12:0] range_r;
  ltpd_cmd_t cmd;
  ltpd_sts_t sts;
  logic [9:0] angle_idx;
  logic [12:0] dist_cm;
  logic signed [17:0] x_mm, y_mm;
  logic [16:0] radius_mm;
  logic signed [15:0] bearing;
  logic [8:0] idx;
  logic zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offx_r <= '0; offy_r <= '0; range_r <= MaxRangeRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegOffX: offx_r <= cfg_data;
        RegOffY: offy_r <= cfg_data;
        RegRange: range_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  ltpd_ctrl #(.PointsPerScan(POINTS_PER_SCAN)) u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_byte(in_tdata),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_kind(out_tuser),
    .out_index(idx), .out_last(out_tlast), .out_zero(zero), .max_range(range_r),
    .cmd, .sts, .angle_idx, .dist_cm
  );

  ltpd_datapath u_dp (
    .clk, .cmd, .sts, .angle_idx, .dist_cm, .off_x(offx_r), .off_y(offy_r),
    .x_mm, .y_mm, .radius_mm, .bearing
  );

  assign out_tdata = zero ? {1'b0, 70'd0, idx} :
                     {2'b0, bearing, radius_mm, y_mm, x_mm, idx};

endmodule

[verif/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ltpd_pkg::*;

  localparam int NumPairs = PointsPerScanDef;
  localparam int SettleCycles = 60;

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] idx;
    logic [17:0] x;
    logic [17:0] y;
    logic [16:0] rad;
    logic [15:0] bear;
    logic last;
  } scan_result_t;

  class telegram_scoreboard;
    scan_result_t pending[$];
    int errors;
    int signed off_x, off_y;
    int unsigned range_cm;
    bit [7:0] window[9];
    int unsigned fill, pos;
    bit payload;
    bit [7:0] low_hold;
    bit [31:0] atan_tab[24];

    function new();
      atan_tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                   32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                   32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                   32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                   32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      off_x = 0;
      off_y = 0;
      range_cm = 7500;
      fill = 0;
      pos = 0;
      payload = 0;
      low_hold = 0;
      errors = 0;
      foreach (window[j]) window[j] = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [15:0] value);
      if (index == RegOffX) off_x = $signed(value);
      else if (index == RegOffY) off_y = $signed(value);
      else if (index == RegRange) range_cm = value[12:0];
    endfunction

    function scan_result_t place_point(int unsigned idx, int unsigned dist_cm);
      scan_result_t r;
      bit [31:0] ang;
      longint x, y, z, c, s, xm, ym, bx, by, dx, dy, t, rad, bear;
      ang = (idx % 720) * HalfDeg;
      x = longint'(dist_cm) * 10 * InvGain;
      y = 0;
      z = ang & 32'h3FFFFFFF;
      for (int k = 0; k < 24; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[k];
        end else begin
          x += dx; y -= dy; z += atan_tab[k];
        end
      end
      case (ang[31:30])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      xm = ((s + 32768) >>> 16) + off_x;
      ym = -((c + 32768) >>> 16) + off_y;
      if (xm == 0 && ym == 0) begin
        rad = 0;
        bear = 0;
      end else begin
        bx = xm * 65536;
        by = ym * 65536;
        z = 0;
        // pre-rotate a quarter turn into the right half plane
        if (bx < 0) begin
          t = bx;
          if (by >= 0) begin
            bx = by; by = -t; z = 64'sh40000000;
          end else begin
            bx = -by; by = t; z = -64'sh40000000;
          end
        end
        for (int k = 0; k < 24; k++) begin
          dx = by >>> k;
          dy = bx >>> k;
          if (by < 0) begin
            bx -= dx; by += dy; z -= atan_tab[k];
          end else begin
            bx += dx; by -= dy; z += atan_tab[k];
          end
        end
        rad = (bx > 0) ? ((bx * InvGain + 64'sd2147483648) >>> 32) : 0;
        if (rad > 131071) rad = 131071;
        bear = (z * longint'(BearMul) + 64'sd2147483648) >>> 32;
        if (bear > BearLimit) bear = BearLimit;
        if (bear < -BearLimit) bear = -BearLimit;
      end
      r.kind = KindPoint;
      r.idx = idx[8:0];
      r.x = xm[17:0];
      r.y = ym[17:0];
      r.rad = rad[16:0];
      r.bear = bear[15:0];
      r.last = (idx == NumPairs - 1);
      return r;
    endfunction

    function void note_byte(bit [7:0] b);
      int unsigned idx, dist_cm;
      bit last, hit;
      scan_result_t r;
      if (payload) begin
        if (!pos[0]) begin
          low_hold = b;
          pos++;
          return;
        end
        idx = pos >> 1;
        pos++;
        dist_cm = low_hold + b[4:0] * 256;
        last = (idx >= NumPairs - 1);
        if (last) begin
          payload = 0;
          fill = 0;
          pos = 0;
        end
        if (dist_cm < range_cm) pending.insert(pending.size(), place_point(idx, dist_cm));
        else if (last) begin
          r = '0;
          r.kind = KindEnd;
          r.idx = idx[8:0];
          r.last = 1;
          pending.insert(pending.size(), r);
        end
        return;
      end
      if (fill >= 6 && b == 8'h01) begin
        hit = window[3] == 8'h02 && window[4] == 8'h80 && window[5] == 8'hD6 &&
              window[6] == 8'h02 && window[7] == 8'hB0 && window[8] == 8'h69;
        if (hit) begin
          payload = 1;
          pos = 0;
          fill = 0;
          return;
        end
      end
      if (fill >= 9 && b == 8'h0A) begin
        hit = window[0] == 8'h06 && window[1] == 8'h02 && window[2] == 8'h80 &&
              window[3] == 8'h03 && window[4] == 8'h00 && window[5] == 8'hA0 &&
              window[6] == 8'h00;
        if (hit) begin
          fill = 0;
          r = '0;
          r.kind = KindStatus;
          pending.insert(pending.size(), r);
          return;
        end
      end
      for (int j = 0; j < 8; j++) window[j] = window[j + 1];
      window[8] = b;
      if (fill < 9) fill++;
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result kind %0d index %0d", got.kind, got.idx);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind) begin
        $error("kind exp %0d got %0d", e.kind, got.kind); errors++;
      end
      if (got.idx != e.idx) begin
        $error("point_index exp %0d got %0d", e.idx, got.idx); errors++;
      end
      if (got.x != e.x) begin
        $error("x_mm exp %0d got %0d", $signed(e.x), $signed(got.x)); errors++;
      end
      if (got.y != e.y) begin
        $error("y_mm exp %0d got %0d", $signed(e.y), $signed(got.y)); errors++;
      end
      if (got.rad != e.rad) begin
        $error("radius_mm exp %0d got %0d", e.rad, got.rad); errors++;
      end
      if (got.bear != e.bear) begin
        $error("bearing exp %0d got %0d", $signed(e.bear), $signed(got.bear)); errors++;
      end
      if (got.last != e.last) begin
        $error("last_in_scan exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [79:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  bit steady = 0;
  telegram_scoreboard sb = new();

  always #5 clk = ~clk;

  lidar_telegram_point_decoder uut (.*);

  task automatic send_byte(bit [7:0] b);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    cfg_we <= 1;
    cfg_index <= index;
    cfg_data <= value;
    sb.set_reg(index, value);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic send_confirm();
    send_byte(8'h06); send_byte(8'h02); send_byte(8'h80); send_byte(8'h03);
    send_byte(8'h00); send_byte(8'hA0); send_byte(8'h00);
    send_byte(8'($urandom_range(0, 255))); send_byte(8'($urandom_range(0, 255)));
    send_byte(8'h0A);
  endtask

  task automatic send_header();
    send_byte(8'h02); send_byte(8'h80); send_byte(8'hD6); send_byte(8'h02);
    send_byte(8'hB0); send_byte(8'h69); send_byte(8'h01);
  endtask

  // pairs with distances biased to zero, the top and the range edge
  task automatic send_pairs(int count, int unsigned range_cm);
    int unsigned d;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0: d = 0;
        1: d = 8191;
        2: d = (range_cm + $urandom_range(0, 2) + 8190) % 8192;
        default: d = $urandom_range(0, 8191);
      endcase
      send_byte(d[7:0]);
      send_byte({3'($urandom), d[12:8]});
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // confirmation with odd filler bytes, then a broken header
    send_confirm();
    send_byte(8'h02); send_byte(8'h80); send_byte(8'hD6); send_byte(8'h02);
    send_byte(8'hB0); send_byte(8'h69); send_byte(8'h00);
    send_byte(8'hFF);
    // one scan, with the registers changed between quarters
    send_header();
    send_pairs(90, 7500);
    drain();
    write_reg(RegOffX, 16'h8000);
    write_reg(RegOffY, 16'h7FFF);
    write_reg(RegRange, 16'h1FFF);
    steady = 1;
    send_pairs(90, 8191);
    steady = 0;
    drain();
    write_reg(RegOffX, 16'h7FFF);
    write_reg(RegOffY, 16'h8000);
    write_reg(RegRange, 16'h0000);
    send_pairs(90, 0);
    drain();
    write_reg(RegOffX, 16'($urandom));
    write_reg(RegOffY, 16'($urandom));
    write_reg(RegRange, 16'($urandom_range(1000, 8191)));
    send_pairs(NumPairs - 270, sb.range_cm);
    drain();
    // hunting resumes after the scan
    for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 255)));
    send_confirm();
    drain();
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_tready <= steady || ($urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result('{out_tuser, out_tdata[8:0], out_tdata[26:9], out_tdata[44:27],
                        out_tdata[61:45], out_tdata[77:62], out_tlast});
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

[files.f]
design/ltpd_pkg.sv
design/ltpd_datapath.sv
design/ltpd_ctrl.sv
design/lidar_telegram_point_decoder.sv
verif/testbench.sv
